@@ sv/gei_pkg.sv @@
// ----------------------------------------------------------------------------
// gei_pkg
// Shared types and constants of the gpio edge interrupt filter with debounce.
// ----------------------------------------------------------------------------
package gei_pkg;

   localparam int NUM_PINS    = 27;
   localparam int PIN_AW      = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
   localparam int USABLE_W    = 27;
   localparam int USABLE_AW   = 5;
   localparam int PIN_W       = 8;
   localparam int TIME_W      = 32;
   localparam int DEB_W       = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = USABLE_W;

   localparam logic             GLOBAL_ENABLE_RESET = 1'b1;
   localparam logic [USABLE_W-1:0] USABLE_RESET     = 27'd76542403;

   typedef enum logic [1:0] {
      OP_EVENT  = 2'd0,
      OP_SETUP  = 2'd1,
      OP_ENABLE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_RISING  = 2'd1,
      MODE_FALLING = 2'd2,
      MODE_BOTH    = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLOBAL_ENABLE = 1'd0,
      CSR_USABLE_PINS   = 1'd1
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [PIN_W-1:0]  pin_index;
      logic              level;
      logic [TIME_W-1:0] now_ms;
      logic [1:0]        edge_mode;
      logic [DEB_W-1:0]  debounce_ms;
      logic              enable_flag;
   } req_type;

   typedef struct packed {
      logic             fired;
      logic [PIN_W-1:0] fired_pin;
      logic             fired_rising;
      logic             status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic              enabled;
      logic [DEB_W-1:0]  debounce;
      logic [TIME_W-1:0] last_time;
      logic              time_valid;
      logic              last_level;
   } entry_type;

   // write-back request from the update logic to the pin table
   typedef struct packed {
      logic              wr_en;
      logic [PIN_AW-1:0] wr_addr;
      entry_type         wr_entry;
   } table_wr_type;

endpackage

@@ sv/gei_req_if.sv @@
// ----------------------------------------------------------------------------
// gei_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface gei_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    operation;
   logic [gei_pkg::PIN_W-1:0]     pin_index;
   logic                          level;
   logic [gei_pkg::TIME_W-1:0]    now_ms;
   logic [1:0]                    edge_mode;
   logic [gei_pkg::DEB_W-1:0]     debounce_ms;
   logic                          enable_flag;

   modport source (
      output valid, operation, pin_index, level, now_ms, edge_mode, debounce_ms,
             enable_flag,
      input  ready
   );
   modport sink (
      input  valid, operation, pin_index, level, now_ms, edge_mode, debounce_ms,
             enable_flag,
      output ready
   );
endinterface

@@ sv/gei_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gei_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface gei_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      fired;
   logic [gei_pkg::PIN_W-1:0] fired_pin;
   logic                      fired_rising;
   logic                      status;

   modport source (
      output valid, fired, fired_pin, fired_rising, status,
      input  ready
   );
   modport sink (
      input  valid, fired, fired_pin, fired_rising, status,
      output ready
   );
endinterface

@@ sv/gei_pin_table.sv @@
// ----------------------------------------------------------------------------
// gei_pin_table
// Per-pin state memory with a registered read, with per-entry valid bits
// so that an entry never written since reset reads as all zero.
// ----------------------------------------------------------------------------
module gei_pin_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [gei_pkg::PIN_AW-1:0]     rd_addr,
   output gei_pkg::entry_type             rd_entry,
   input  gei_pkg::table_wr_type          wr
);

   gei_pkg::entry_type             mem [gei_pkg::NUM_PINS];
   logic [gei_pkg::NUM_PINS-1:0]   valid_ff;
   logic [gei_pkg::NUM_PINS-1:0]   valid_in;
   gei_pkg::entry_type             rd_data_ff;
   logic                           rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.wr_en) begin
         valid_in[wr.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr.wr_addr] <= wr.wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // entries not yet written hold the cleared pin state
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ sv/gei_update.sv @@
// ----------------------------------------------------------------------------
// gei_update
// Qualifies an edge event against the pin entry, runs the debounce check and
// builds the write-back entry and the result for every operation.
// ----------------------------------------------------------------------------
module gei_update (
   input  gei_pkg::req_type                 req,
   input  gei_pkg::entry_type               entry,
   input  logic                             global_enable,
   input  logic [gei_pkg::USABLE_W-1:0]     usable_pins,
   output gei_pkg::table_wr_type            wr,
   output gei_pkg::rsp_type                 rsp
);

   logic                       in_range;
   logic                       usable;
   logic                       edge_match;
   logic                       qualify;
   logic                       reject;
   logic                       fire;
   logic                       deb_on;
   logic [gei_pkg::TIME_W-1:0] elapsed;
   gei_pkg::entry_type         ev_entry;
   gei_pkg::entry_type         setup_entry;

   always_comb begin
      in_range = ({24'd0, req.pin_index} < 32'(gei_pkg::NUM_PINS));
      usable   = in_range && ({24'd0, req.pin_index} < 32'(gei_pkg::USABLE_W))
                 && usable_pins[req.pin_index[gei_pkg::USABLE_AW-1:0]];

      edge_match = (entry.mode == gei_pkg::MODE_BOTH) ||
                   (req.level  && (entry.mode == gei_pkg::MODE_RISING)) ||
                   (!req.level && (entry.mode == gei_pkg::MODE_FALLING));
      qualify = global_enable && entry.enabled && edge_match &&
                ((entry.mode != gei_pkg::MODE_BOTH) || (req.level != entry.last_level));
      deb_on  = (entry.debounce != '0);
      elapsed = req.now_ms - entry.last_time;
      reject  = qualify && deb_on && entry.time_valid &&
                (elapsed < {16'd0, entry.debounce});
      fire    = qualify && !reject;

      ev_entry = entry;
      // last time moves on every qualifying event with debounce on, rejected or not
      if (qualify && deb_on) begin
         ev_entry.last_time  = req.now_ms;
         ev_entry.time_valid = 1'b1;
      end
      if (fire && (entry.mode == gei_pkg::MODE_BOTH)) begin
         ev_entry.last_level = req.level;
      end

      setup_entry = '0;
      if (req.edge_mode != gei_pkg::MODE_NONE) begin
         setup_entry.mode     = req.edge_mode;
         setup_entry.enabled  = 1'b1;
         setup_entry.debounce = req.debounce_ms;
      end

      wr          = '0;
      wr.wr_addr  = req.pin_index[gei_pkg::PIN_AW-1:0];
      rsp         = '0;

      case (req.operation)
         gei_pkg::OP_EVENT: begin
            rsp.status  = !in_range;
            wr.wr_en    = in_range;
            wr.wr_entry = ev_entry;
            if (in_range && fire) begin
               rsp.fired        = 1'b1;
               rsp.fired_pin    = req.pin_index;
               rsp.fired_rising = req.level;
            end
         end
         gei_pkg::OP_SETUP: begin
            rsp.status  = !usable;
            wr.wr_en    = usable;
            wr.wr_entry = setup_entry;
         end
         gei_pkg::OP_ENABLE: begin
            rsp.status               = !usable;
            wr.wr_en                 = usable;
            wr.wr_entry              = entry;
            wr.wr_entry.enabled      = req.enable_flag;
         end
         default: begin
            wr.wr_en = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/gpio_edge_irq_filter_debounce.sv @@
// ----------------------------------------------------------------------------
// gpio_edge_irq_filter_debounce
// GPIO edge interrupt filter with per-pin mode, enable and debounce, kept in a
// pin table memory that is read, updated and written back per request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  req      in         valid / ready    operation, pin, level, time, setup
//  rsp      out        valid / ready    fired, fired_pin, fired_rising, status
//  csr      in         write enable     register index, write data
//
//  a request is read from the table on accept, then updated and written
//  back in the lookup state; the registered table read and the write-back
//  that must land before the next read set this order
//  synchronous reset clears the state, response valid and table valid bits
//  at once and loads the csr reset values, so no clearing pass is needed
//  a held response stalls the update cycle; a new request is taken while a
//  finished response still waits
// ----------------------------------------------------------------------------
module gpio_edge_irq_filter_debounce (
   input  logic                                clock,
   input  logic                                reset,
   gei_req_if.sink                             req_chan,
   gei_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [gei_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gei_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   state_type                       state_ff, state_in;
   gei_pkg::req_type                req_ff, req_in;
   gei_pkg::rsp_type                rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            global_enable_ff, global_enable_in;
   logic [gei_pkg::USABLE_W-1:0]    usable_ff, usable_in;

   gei_pkg::req_type                req_payload;
   gei_pkg::entry_type              rd_entry;
   gei_pkg::table_wr_type           upd_wr;
   gei_pkg::table_wr_type           table_wr;
   gei_pkg::rsp_type                upd_rsp;
   logic                            accept;
   logic                            finish;
   logic                            rd_in_range;
   logic [gei_pkg::PIN_AW-1:0]      rd_addr;

   assign req_payload = '{operation:   req_chan.operation,
                          pin_index:   req_chan.pin_index,
                          level:       req_chan.level,
                          now_ms:      req_chan.now_ms,
                          edge_mode:   req_chan.edge_mode,
                          debounce_ms: req_chan.debounce_ms,
                          enable_flag: req_chan.enable_flag};

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign finish         = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_chan.ready);

   // out-of-range pins read entry zero; the result ignores it
   assign rd_in_range = ({24'd0, req_chan.pin_index} < 32'(gei_pkg::NUM_PINS));
   assign rd_addr     = rd_in_range ? req_chan.pin_index[gei_pkg::PIN_AW-1:0] : '0;

   gei_pin_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr       (table_wr)
   );

   gei_update u_update (
      .req           (req_ff),
      .entry         (rd_entry),
      .global_enable (global_enable_ff),
      .usable_pins   (usable_ff),
      .wr            (upd_wr),
      .rsp           (upd_rsp)
   );

   always_comb begin
      table_wr       = upd_wr;
      table_wr.wr_en = upd_wr.wr_en && finish;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_payload;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (finish) begin
               rsp_in       = upd_rsp;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      global_enable_in = global_enable_ff;
      usable_in        = usable_ff;
      if (csr_write_enable) begin
         case (csr_index)
            gei_pkg::CSR_GLOBAL_ENABLE: global_enable_in = csr_write_data[0];
            gei_pkg::CSR_USABLE_PINS:   usable_in        = csr_write_data;
            default: begin
               global_enable_in = global_enable_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         global_enable_ff <= gei_pkg::GLOBAL_ENABLE_RESET;
         usable_ff        <= gei_pkg::USABLE_RESET;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         global_enable_ff <= global_enable_in;
         usable_ff        <= usable_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.fired        = rsp_ff.fired;
   assign rsp_chan.fired_pin    = rsp_ff.fired_pin;
   assign rsp_chan.fired_rising = rsp_ff.fired_rising;
   assign rsp_chan.status       = rsp_ff.status;

endmodule

@@ tb/gei_irq_checker.sv @@
// ----------------------------------------------------------------------------
// gei_irq_checker
// Watches the request, response and csr ports of the gpio edge interrupt
// filter, keeps its own copy of the pin table and registers, works out the
// response of every accepted request and compares it with what the block
// returns, in order.
// ----------------------------------------------------------------------------
module gei_irq_checker (
   input  logic                               clock,
   input  logic                               reset,
   gei_req_if                                 req_mon,
   gei_rsp_if                                 rsp_mon,
   input  logic                               csr_write_enable,
   input  logic [gei_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gei_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output int                                 fail_count,
   output int                                 outstanding,
   output int                                 rsp_count,
   output int                                 fired_count,
   output int                                 invalid_count
);

   import gei_pkg::*;

   logic                   global_en;
   logic [USABLE_W-1:0]    usable_mask;
   entry_type              pin_tbl [NUM_PINS];
   rsp_type                expected_rsp_q [$];
   int                     mismatches;
   int                     checked;
   int                     fired_seen;
   int                     invalid_seen;

   assign fail_count    = mismatches;
   assign rsp_count     = checked;
   assign fired_count   = fired_seen;
   assign invalid_count = invalid_seen;

   function automatic logic pin_usable(input logic [PIN_W-1:0] pin);
      return ({24'd0, pin} < 32'(NUM_PINS)) && ({24'd0, pin} < 32'(USABLE_W)) &&
             usable_mask[pin[USABLE_AW-1:0]];
   endfunction

   // applies one request to the pin table and returns the response it causes
   function automatic rsp_type filter_request(input req_type r);
      rsp_type           o;
      entry_type         e;
      logic              pass;
      logic [1:0]        edge_kind;
      int unsigned       p;
      logic [PIN_AW-1:0] idx;
      o = '0;
      p = 32'(r.pin_index);
      idx = r.pin_index[PIN_AW-1:0];
      case (r.operation)
         OP_EVENT: begin
            if (p >= NUM_PINS) begin
               o.status = 1'b1;
            end else if (global_en) begin
               e = pin_tbl[idx];
               edge_kind = r.level ? MODE_RISING : MODE_FALLING;
               if ((e.mode == edge_kind || e.mode == MODE_BOTH) && e.enabled) begin
                  pass = 1'b1;
                  if (e.mode == MODE_BOTH) pass = (r.level != e.last_level);
                  // the time stamp moves on even when debounce rejects
                  if (pass && e.debounce != '0) begin
                     if (e.time_valid && (r.now_ms - e.last_time) < {16'd0, e.debounce})
                        pass = 1'b0;
                     e.last_time  = r.now_ms;
                     e.time_valid = 1'b1;
                  end
                  if (pass) begin
                     o.fired        = 1'b1;
                     o.fired_pin    = r.pin_index;
                     o.fired_rising = r.level;
                     if (e.mode == MODE_BOTH) e.last_level = r.level;
                  end
                  pin_tbl[idx] = e;
               end
            end
         end
         OP_SETUP: begin
            if (!pin_usable(r.pin_index)) begin
               o.status = 1'b1;
            end else begin
               e = '0;
               if (r.edge_mode != MODE_NONE) begin
                  e.mode     = r.edge_mode;
                  e.enabled  = 1'b1;
                  e.debounce = r.debounce_ms;
               end
               pin_tbl[idx] = e;
            end
         end
         OP_ENABLE: begin
            if (!pin_usable(r.pin_index)) o.status = 1'b1;
            else pin_tbl[idx].enabled = r.enable_flag;
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : watch
      req_type r;
      rsp_type got;
      rsp_type want;
      if (reset) begin
         global_en   = GLOBAL_ENABLE_RESET;
         usable_mask = USABLE_RESET;
         foreach (pin_tbl[i]) pin_tbl[i] = '0;
         expected_rsp_q.delete();
         mismatches   = 0;
         checked      = 0;
         fired_seen   = 0;
         invalid_seen = 0;
         outstanding <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GLOBAL_ENABLE: global_en   = csr_write_data[0];
               CSR_USABLE_PINS:   usable_mask = csr_write_data[USABLE_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            r.operation   = req_mon.operation;
            r.pin_index   = req_mon.pin_index;
            r.level       = req_mon.level;
            r.now_ms      = req_mon.now_ms;
            r.edge_mode   = req_mon.edge_mode;
            r.debounce_ms = req_mon.debounce_ms;
            r.enable_flag = req_mon.enable_flag;
            expected_rsp_q.push_back(filter_request(r));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.fired        = rsp_mon.fired;
            got.fired_pin    = rsp_mon.fired_pin;
            got.fired_rising = rsp_mon.fired_rising;
            got.status       = rsp_mon.status;
            if (expected_rsp_q.size() == 0) begin
               if (mismatches < 10)
                  $display("response %0d arrived with no request outstanding", checked);
               mismatches++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.fired !== want.fired || got.fired_pin !== want.fired_pin ||
                   got.fired_rising !== want.fired_rising || got.status !== want.status) begin
                  if (mismatches < 10)
                     $display({"response %0d: expected fired=%0b pin=%0d rising=%0b ",
                               "status=%0b, got fired=%0b pin=%0d rising=%0b status=%0b"},
                              checked, want.fired, want.fired_pin, want.fired_rising,
                              want.status, got.fired, got.fired_pin, got.fired_rising,
                              got.status);
                  mismatches++;
               end
               if (want.fired) fired_seen++;
               if (want.status) invalid_seen++;
            end
            checked++;
         end
         outstanding <= expected_rsp_q.size();
      end
   end

endmodule

@@ tb/gpio_edge_irq_filter_debounce_tb.sv @@
// ----------------------------------------------------------------------------
// gpio_edge_irq_filter_debounce_tb
// Drives the edge interrupt filter with directed and random pin setup, enable
// and edge requests under several register settings, with random gaps on the
// request side and random stalls on the response side; the checker beside
// the block predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
module gpio_edge_irq_filter_debounce_tb;

   import gei_pkg::*;

   localparam int         CYCLE_LIMIT = 1000000;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [CSR_DATA_W-1:0] ALL_PINS = {CSR_DATA_W{1'b1}};

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_write_data;

   int                       fail_count;
   int                       outstanding;
   int                       rsp_count;
   int                       fired_count;
   int                       invalid_count;
   int                       cycle_count = 0;
   int                       settings_done = 0;
   bit                       valid_up = 1'b0;
   bit                       burst = 1'b0;
   logic [TIME_W-1:0]        ms_clock;

   gei_req_if req_chan ();
   gei_rsp_if rsp_chan ();

   gpio_edge_irq_filter_debounce uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   gei_irq_checker irq_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .rsp_count        (rsp_count),
      .fired_count      (fired_count),
      .invalid_count    (invalid_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 85) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input logic [PIN_W-1:0] pin,
                                        input logic lvl, input logic [TIME_W-1:0] now,
                                        input logic [1:0] mode, input logic [DEB_W-1:0] deb,
                                        input logic en);
      req_type r;
      r.operation   = op;
      r.pin_index   = pin;
      r.level       = lvl;
      r.now_ms      = now;
      r.edge_mode   = mode;
      r.debounce_ms = deb;
      r.enable_flag = en;
      return r;
   endfunction

   // response side: random stalls, with stretches of steady ready
   initial begin
      int  stall;
      int  stretch;
      bit  steady;
      logic rdy;
      stall   = 0;
      stretch = 0;
      steady  = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            steady  = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(20, 200);
         end else begin
            stretch--;
         end
         if (stall > 0) begin
            rdy = 1'b0;
            stall--;
         end else begin
            rdy = 1'b1;
            if (!steady) stall = gap_len();
         end
         rsp_chan.ready <= rdy;
      end
   end

   task automatic drop_valid();
      if (valid_up) begin
         req_chan.valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   task automatic send(input req_type r);
      int g;
      g = burst ? 0 : gap_len();
      if (g > 0) begin
         drop_valid();
         repeat (g) @(posedge clock);
      end
      req_chan.operation   <= r.operation;
      req_chan.pin_index   <= r.pin_index;
      req_chan.level       <= r.level;
      req_chan.now_ms      <= r.now_ms;
      req_chan.edge_mode   <= r.edge_mode;
      req_chan.debounce_ms <= r.debounce_ms;
      req_chan.enable_flag <= r.enable_flag;
      req_chan.valid       <= 1'b1;
      valid_up = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic hold_until_drained();
      drop_valid();
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      hold_until_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_done++;
   endtask

   task automatic run_phase(input logic ge, input logic [CSR_DATA_W-1:0] mask,
                            input int count, input logic [TIME_W-1:0] start_ms);
      req_type          r;
      logic [PIN_W-1:0] hot [4];
      int unsigned      k;
      write_csr(CSR_GLOBAL_ENABLE, {{(CSR_DATA_W-1){1'b0}}, ge});
      write_csr(CSR_USABLE_PINS, mask);
      ms_clock = start_ms;
      foreach (hot[i]) hot[i] = PIN_W'($urandom_range(0, NUM_PINS-1));
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
         if (n == count / 2) hold_until_drained();
         k = $urandom_range(0, 99);
         if (k < 72) r.operation = OP_EVENT;
         else if (k < 86) r.operation = OP_SETUP;
         else if (k < 97) r.operation = OP_ENABLE;
         else r.operation = OP_UNUSED;
         // a few hot pins so events pile up on pins that were set up
         k = $urandom_range(0, 99);
         if (k < 50) r.pin_index = hot[2'($urandom_range(0, 3))];
         else if (k < 92) r.pin_index = PIN_W'($urandom_range(0, NUM_PINS-1));
         else r.pin_index = PIN_W'($urandom_range(0, 255));
         r.level = 1'($urandom_range(0, 1));
         k = $urandom_range(0, 99);
         if (k < 4) ms_clock = $urandom();
         else ms_clock = ms_clock + $urandom_range(0, 250);
         r.now_ms = (k > 96) ? $urandom() : ms_clock;
         r.edge_mode = 2'($urandom_range(0, 3));
         k = $urandom_range(0, 99);
         if (k < 30) r.debounce_ms = '0;
         else if (k < 85) r.debounce_ms = DEB_W'($urandom_range(1, 300));
         else if (k < 95) r.debounce_ms = DEB_W'($urandom_range(0, 65535));
         else r.debounce_ms = {DEB_W{1'b1}};
         r.enable_flag = ($urandom_range(0, 4) != 0);
         send(r);
      end
      burst = 1'b0;
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_GLOBAL_ENABLE;
      csr_write_data   <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.operation   <= OP_EVENT;
      req_chan.pin_index   <= '0;
      req_chan.level       <= 1'b0;
      req_chan.now_ms      <= '0;
      req_chan.edge_mode   <= MODE_NONE;
      req_chan.debounce_ms <= '0;
      req_chan.enable_flag <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset register values
      send(make_req(OP_SETUP,  8'd0,   1'b0, 32'd0,         MODE_RISING,  16'd0,      1'b0));
      send(make_req(OP_EVENT,  8'd0,   1'b1, 32'd5,         MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_EVENT,  8'd0,   1'b0, 32'd6,         MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_ENABLE, 8'd0,   1'b0, 32'd0,         MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_EVENT,  8'd0,   1'b1, 32'd7,         MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_ENABLE, 8'd0,   1'b0, 32'd0,         MODE_NONE,    16'd0,      1'b1));
      // both edges with debounce across the time wrap
      send(make_req(OP_SETUP,  8'd1,   1'b0, 32'd0,         MODE_BOTH,    16'd100,    1'b0));
      send(make_req(OP_EVENT,  8'd1,   1'b1, 32'hFFFFFFF0,  MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_EVENT,  8'd1,   1'b0, 32'h00000022,  MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_EVENT,  8'd1,   1'b0, 32'h000000B8,  MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_EVENT,  8'd1,   1'b0, 32'h00000200,  MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_SETUP,  8'd6,   1'b0, 32'd0,         MODE_FALLING, 16'hFFFF,   1'b0));
      send(make_req(OP_EVENT,  8'd6,   1'b0, 32'd0,         MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_EVENT,  8'd6,   1'b0, 32'hFFFFFFFF,  MODE_NONE,    16'd0,      1'b0));
      // unusable and out of range pins
      send(make_req(OP_SETUP,  8'd2,   1'b0, 32'd0,         MODE_RISING,  16'd10,     1'b0));
      send(make_req(OP_ENABLE, 8'd2,   1'b0, 32'd0,         MODE_NONE,    16'd0,      1'b1));
      send(make_req(OP_EVENT,  8'd26,  1'b1, 32'd9,         MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_EVENT,  8'd27,  1'b1, 32'd9,         MODE_NONE,    16'd0,      1'b0));
      send(make_req(OP_EVENT,  8'd255, 1'b1, 32'hFFFFFFFF,  MODE_BOTH,    16'hFFFF,   1'b1));
      send(make_req(OP_SETUP,  8'd255, 1'b1, 32'hFFFFFFFF,  MODE_BOTH,    16'hFFFF,   1'b1));
      send(make_req(OP_UNUSED, 8'd255, 1'b1, 32'hFFFFFFFF,  MODE_BOTH,    16'hFFFF,   1'b1));
      // mode none clears the pin
      send(make_req(OP_SETUP,  8'd0,   1'b0, 32'd0,         MODE_NONE,    16'd5,      1'b1));
      send(make_req(OP_EVENT,  8'd0,   1'b1, 32'd100,       MODE_NONE,    16'd0,      1'b0));
      // global enable off ignores events
      write_csr(CSR_GLOBAL_ENABLE, '0);
      send(make_req(OP_EVENT,  8'd1,   1'b1, 32'h00001000,  MODE_NONE,    16'd0,      1'b0));
      write_csr(CSR_GLOBAL_ENABLE, {{(CSR_DATA_W-1){1'b0}}, 1'b1});

      run_phase(1'b1, ALL_PINS,                      300, 32'd0);
      run_phase(1'b1, CSR_DATA_W'($urandom()),       300, $urandom());
      run_phase(1'b0, CSR_DATA_W'($urandom()),       250, $urandom());
      run_phase(1'b1, '0,                            200, $urandom());
      run_phase(1'b1, CSR_DATA_W'(USABLE_RESET),     300, $urandom());
      run_phase(1'b1, ALL_PINS,                      400, 32'hFFFFF000);

      hold_until_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d requests: %0d interrupts delivered, %0d invalid-pin statuses",
               rsp_count, fired_count, invalid_count);
      $display("register settings applied: %0d, mismatches: %0d", settings_done, fail_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
